// ===== rtl/exrpbd_pkg.sv =====
// shared constants, codes and types of the exr predictor / byte deinterleave block
// no dependencies; the controller, datapath and top level refer to it by scoped names
package exrpbd_pkg;

	localparam int unsigned MAX_BYTES = 8192;
	localparam int unsigned ADDR_W    = $clog2(MAX_BYTES);
	localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);

	localparam logic [7:0] PRED_BIAS = 8'd128;

	// item action codes
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_FETCH
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic read;
		logic emit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

// ===== rtl/exrpbd_ifs.sv =====
// channel interfaces of the exr predictor / byte deinterleave block
// depends on nothing; used by the top level
interface exrpbd_item_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;
	logic       first;
	modport source (output valid, action, data_byte, first, input ready);
	modport sink   (input valid, action, data_byte, first, output ready);
endinterface

interface exrpbd_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;
	logic       error;
	modport source (output valid, out_byte, last, error, input ready);
	modport sink   (input valid, out_byte, last, error, output ready);
endinterface

interface exrpbd_cfg_if;
	logic valid;
	logic ready;
	logic raw_mode;
	modport source (output valid, raw_mode, input ready);
	modport sink   (input valid, raw_mode, output ready);
endinterface

// ===== rtl/exrpbd_ctrl.sv =====
// controller of the exr predictor / byte deinterleave block
// depends on exrpbd_pkg
module exrpbd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic                  item_action,
	input  exrpbd_pkg::dp_status_t stat,
	output logic                  item_ready,
	output exrpbd_pkg::dp_cmd_t   cmd
);

	exrpbd_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= exrpbd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		cmd        = '0;
		case (state_q)
			exrpbd_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (item_action == exrpbd_pkg::ACT_READ) begin
						cmd.read = 1'b1;
						state_d  = exrpbd_pkg::ST_FETCH;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			exrpbd_pkg::ST_FETCH: begin
				// wait for room in the output register
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = exrpbd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = exrpbd_pkg::ST_IDLE;
			end
		endcase
	end

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.read, cmd.emit}))
		else $error("more than one datapath command at once");

	a_read_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.read |=> state_q == exrpbd_pkg::ST_FETCH)
		else $error("read accepted without fetch");

	a_fetch_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == exrpbd_pkg::ST_FETCH && !stat.out_free) |=>
		state_q == exrpbd_pkg::ST_FETCH)
		else $error("fetch left while output register busy");

endmodule

// ===== rtl/exrpbd_dp.sv =====
// datapath: counts, predictor, byte store and output register
// depends on exrpbd_pkg
module exrpbd_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  exrpbd_pkg::dp_cmd_t    cmd,
	output exrpbd_pkg::dp_status_t stat,
	input  logic [7:0]             data_byte,
	input  logic                   first,
	input  logic                   cfg_wr,
	input  logic                   cfg_raw_mode,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [7:0]             out_byte,
	output logic                   out_last,
	output logic                   out_error
);

	localparam int unsigned AW = exrpbd_pkg::ADDR_W;
	localparam int unsigned CW = exrpbd_pkg::CNT_W;
	localparam logic [CW-1:0] FULL = CW'(exrpbd_pkg::MAX_BYTES);

	logic [7:0]    mem [exrpbd_pkg::MAX_BYTES];
	logic          raw_q;
	logic [CW-1:0] load_count_q;
	logic [CW-1:0] read_count_q;
	logic [7:0]    prev_q;
	logic [7:0]    rdata_s1;
	logic          err_s1;
	logic          last_s1;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_last_q;
	logic          out_error_q;

	// load side
	logic [CW-1:0] base;
	logic          full;
	logic [7:0]    store_val;
	logic          mem_we;

	assign base      = first ? '0 : load_count_q;
	assign full      = (base == FULL);
	assign store_val = (raw_q || base == '0) ? data_byte
	                 : prev_q + data_byte + exrpbd_pkg::PRED_BIAS;
	assign mem_we    = cmd.load && !full;

	// read side
	logic          rd_err;
	logic [CW-1:0] half;
	logic [CW-1:0] rd_idx;
	logic          mem_re;

	assign rd_err = (read_count_q >= load_count_q);
	assign half   = (load_count_q + CW'(1)) >> 1;
	always_comb begin
		if (raw_q) begin
			rd_idx = read_count_q;
		end else if (read_count_q[0]) begin
			rd_idx = half + (read_count_q >> 1);
		end else begin
			rd_idx = read_count_q >> 1;
		end
	end
	assign mem_re = cmd.read && !rd_err;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[base[AW-1:0]] <= store_val;
		end
		if (mem_re) begin
			rdata_s1 <= mem[rd_idx[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q        <= 1'b0;
			load_count_q <= '0;
			read_count_q <= '0;
			prev_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				raw_q <= cfg_raw_mode;
			end
			if (cmd.load) begin
				// a new block restarts at base zero, which is never full
				if (first) begin
					read_count_q <= '0;
				end
				if (!full) begin
					prev_q       <= store_val;
					load_count_q <= base + CW'(1);
				end
			end
			if (mem_re) begin
				read_count_q <= read_count_q + CW'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			err_s1  <= rd_err;
			last_s1 <= !rd_err && (read_count_q + CW'(1) == load_count_q);
		end
		if (cmd.emit) begin
			out_byte_q  <= err_s1 ? 8'd0 : rdata_s1;
			out_last_q  <= last_s1;
			out_error_q <= err_s1;
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign out_last      = out_last_q;
	assign out_error     = out_error_q;

	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		read_count_q <= load_count_q && load_count_q <= FULL)
		else $error("read count passed load count");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_error_q) |-> (out_byte_q == 8'd0 && !out_last_q))
		else $error("error result carries data");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.emit)
		else $error("pending result overwritten");

endmodule

// ===== rtl/exrpbd_top.sv =====
// top level of the exr predictor / byte deinterleave block
// depends on exrpbd_pkg, exrpbd_ifs, exrpbd_ctrl and exrpbd_dp
//
// rebuilds the bytes of one run-length-decoded image block. a load transaction
// (action = load) stores one byte; outside raw mode the delta predictor is
// undone on the way in (first byte of a block as is, then previous byte plus
// incoming byte minus 128, mod 256). a read transaction returns the next byte,
// interleaved outside raw mode (first half and second half alternate, the first
// half holding the extra byte when the count is odd), in load order in raw
// mode. a read with nothing left returns error = 1 with a zero byte. first = 1
// on a load starts a new block. up to 8192 bytes per block; further loads are
// dropped. loads can stream back to back while no read is in progress. a read
// fetches its byte via the registered read port of the store, then moves it
// into the output register; a stalled output holds the read in fetch. loads
// are still taken while a finished result waits on the output. the store needs
// no clearing after reset, since only entries below the fill count are ever
// read. raw_mode is written through the config channel, which is always ready;
// the user writes it only while the block is idle; the block does not enforce it.
module exr_predictor_byte_deinterleave_top (
	input  logic               clk,
	input  logic               arst_n,
	exrpbd_item_if.sink        item,
	exrpbd_result_if.source    result,
	exrpbd_cfg_if.sink         cfg
);

	exrpbd_pkg::dp_cmd_t    cmd;
	exrpbd_pkg::dp_status_t stat;

	// config register always takes its transaction
	assign cfg.ready = 1'b1;

	// sequencing of loads, reads and result hand-off
	exrpbd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_action (item.action),
		.stat        (stat),
		.item_ready  (item.ready),
		.cmd         (cmd)
	);

	// counts, predictor, byte store and output register
	exrpbd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.data_byte    (item.data_byte),
		.first        (item.first),
		.cfg_wr       (cfg.valid),
		.cfg_raw_mode (cfg.raw_mode),
		.out_ready    (result.ready),
		.out_valid    (result.valid),
		.out_byte     (result.out_byte),
		.out_last     (result.last),
		.out_error    (result.error)
	);

endmodule
